// File: rtl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants of the round-robin thread scheduler
// Holds the slot geometry, command codes, slot states, the datapath command
// enum and the status and result structs of the controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package rrts_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = 4;
  localparam int IDLE_SLOT = 1;
  localparam int CNT_W     = 32;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [3:0] {
    OP_TICK   = 4'd0,
    OP_YIELD  = 4'd1,
    OP_SLEEP  = 4'd2,
    OP_BLOCK  = 4'd3,
    OP_WAKE   = 4'd4,
    OP_EXIT   = 4'd5,
    OP_CREATE = 4'd6,
    OP_REAP   = 4'd7,
    OP_SWITCH = 4'd8
  } opcode_t;

  typedef enum logic [1:0] {
    ST_RUNNING  = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_SLEEPING = 2'd2,
    ST_DEAD     = 2'd3
  } slot_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SWEEP,
    S_PREEMPT,
    S_PICK_INIT,
    S_PICK_STEP,
    S_SWITCH,
    S_REAP_INIT,
    S_REAP_STEP,
    S_REAP_CLOSE,
    S_DONE
  } fsm_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_SWEEP,
    DP_PREEMPT,
    DP_PICK_INIT,
    DP_PICK_STEP,
    DP_SWITCH,
    DP_REAP_INIT,
    DP_REAP_STEP,
    DP_REAP_CLOSE
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic pick_end;
    logic reap_end;
  } dp_status_t;

  typedef struct packed {
    logic [CNT_W-1:0] preemptions;
    logic [CNT_W-1:0] tick_value;
    slot_t            new_slot;
    logic             status;
    logic             switched;
    slot_t            current_slot;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/round_robin_thread_scheduler_core.sv
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_core: hardware thread-slot scheduler
// Takes one scheduling command per item and returns the running slot and
// counters after it.
// ----------------------------------------------------------------------------
// Usage. Commands enter on the in_ stream (tick, yield, sleep, block, wake,
// exit, create, reap, switch); each gives exactly one result item on the
// out_ stream with the slot now running, whether it changed, create status
// and slot, and the tick and preemption counters.
// The slot walks go one slot per cycle. A block, wake, create or unknown
// command needs no walk; a yield, sleep, exit or switch walks the
// creation-order list; a tick first sweeps all 16 wake timers, then applies
// the preemption and walks; a reap walks the whole list. One command is
// worked on at a time, and the block is ready for the next one in the cycle
// after the result has entered the output register.
// When the receiver stalls and the output register is still full, the
// finished result waits in the datapath, in_tready stays low and no further
// item is accepted until the register frees.
// After reset slot 0 runs, slot 1 (idle) is runnable, all other slots are
// free and both counters are zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module round_robin_thread_scheduler_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // opcode[3:0], sleep_ticks[35:4], target_slot[39:36]
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // current_slot[3:0], switched[4], status[5], new_slot[9:6],
  // tick_value[41:10], preemptions[73:42], zero[79:74]
  output logic [79:0]      out_tdata
);
  import rrts_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;
  result_t    res;
  logic       out_load;
  logic       out_free;
  logic       out_valid_r, out_valid_nxt;
  logic [79:0] out_data_r;

  // The output register is free when empty or being emptied this cycle.
  assign out_free = !out_valid_r || out_tready;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .opcode    (in_tdata[3:0]),
    .st        (st),
    .out_free  (out_free),
    .in_tready (in_tready),
    .cmd       (cmd),
    .out_load  (out_load)
  );

  rrts_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .opcode      (in_tdata[3:0]),
    .sleep_ticks (in_tdata[35:4]),
    .target_slot (in_tdata[39:36]),
    .st          (st),
    .res         (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load)                    out_valid_nxt = 1'b1;
    else if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= {6'd0, res};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("result loaded over a pending result");
`endif

endmodule
`default_nettype wire

// File: rtl/rrts_ctrl.sv
// ----------------------------------------------------------------------------
// rrts_ctrl: command sequencer of the thread scheduler
// Decodes each accepted command and steps the datapath through the wake
// sweep, the preemption, the pick walk, the switch and the reap walk.
// ----------------------------------------------------------------------------
`default_nettype none
module rrts_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  input  wire logic [3:0]          opcode,
  input  wire rrts_pkg::dp_status_t st,
  input  wire logic                out_free,
  output logic                     in_tready,
  output rrts_pkg::dp_cmd_t        cmd,
  output logic                     out_load
);
  import rrts_pkg::*;

  fsm_state_t state_r, state_nxt;
  opcode_t    op;

  assign op = opcode_t'(opcode);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (op)
            OP_TICK:                               state_nxt = S_SWEEP;
            OP_YIELD, OP_SLEEP, OP_EXIT, OP_SWITCH: state_nxt = S_PICK_INIT;
            OP_REAP:                               state_nxt = S_REAP_INIT;
            default:                               state_nxt = S_DONE;
          endcase
        end
      end
      S_SWEEP:      if (st.sweep_last) state_nxt = S_PREEMPT;
      S_PREEMPT:    state_nxt = S_PICK_INIT;
      S_PICK_INIT:  state_nxt = S_PICK_STEP;
      S_PICK_STEP:  if (st.pick_end) state_nxt = S_SWITCH;
      S_SWITCH:     state_nxt = S_DONE;
      S_REAP_INIT:  state_nxt = S_REAP_STEP;
      S_REAP_STEP:  if (st.reap_end) state_nxt = S_REAP_CLOSE;
      S_REAP_CLOSE: state_nxt = S_DONE;
      S_DONE:       if (out_free) state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    cmd       = DP_NOP;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd = DP_LOAD;
      end
      S_SWEEP:      cmd = DP_SWEEP;
      S_PREEMPT:    cmd = DP_PREEMPT;
      S_PICK_INIT:  cmd = DP_PICK_INIT;
      S_PICK_STEP:  cmd = DP_PICK_STEP;
      S_SWITCH:     cmd = DP_SWITCH;
      S_REAP_INIT:  cmd = DP_REAP_INIT;
      S_REAP_STEP:  cmd = DP_REAP_STEP;
      S_REAP_CLOSE: cmd = DP_REAP_CLOSE;
      S_DONE:       out_load = out_free;
      default:      cmd = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/rrts_dp.sv
// ----------------------------------------------------------------------------
// rrts_dp: slot table and walkers of the thread scheduler
// Holds the slot states, wake ticks, creation-order links and counters, and
// performs one walk step per command from the controller.
// ----------------------------------------------------------------------------
`default_nettype none
module rrts_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rrts_pkg::dp_cmd_t    cmd,
  input  wire logic [3:0]           opcode,
  input  wire logic [31:0]          sleep_ticks,
  input  wire logic [3:0]           target_slot,
  output rrts_pkg::dp_status_t      st,
  output rrts_pkg::result_t         res
);
  import rrts_pkg::*;

  localparam slot_t LAST_IDX = slot_t'(NUM_SLOTS - 1);
  localparam slot_t IDLE     = slot_t'(IDLE_SLOT);

  slot_state_t      state_r [NUM_SLOTS];
  slot_state_t      state_nxt [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] wake_r [NUM_SLOTS];
  logic [CNT_W-1:0] wake_nxt [NUM_SLOTS];
  slot_t            next_r [NUM_SLOTS];
  slot_t            next_nxt [NUM_SLOTS];
  slot_t            last_r, last_nxt;
  slot_t            run_r, run_nxt;
  slot_t            before_r, before_nxt;
  logic [CNT_W-1:0] tick_r, tick_nxt;
  logic [CNT_W-1:0] pre_r, pre_nxt;
  logic             status_r, status_nxt;
  slot_t            newslot_r, newslot_nxt;
  slot_t            ptr_r, ptr_nxt;
  slot_t            start_r, start_nxt;
  slot_t            cnt_r, cnt_nxt;
  slot_t            pick_r, pick_nxt;
  logic             found_r, found_nxt;
  slot_t            pk_r, pk_nxt;
  slot_t            fk_r, fk_nxt;
  logic             havek_r, havek_nxt;

  opcode_t          op;
  logic             hit;
  logic             free_ok;
  slot_t            free_slot;
  logic [CNT_W:0]   sum;
  slot_t            nx;

  assign op = opcode_t'(opcode);
  assign hit = used_r[ptr_r] && (state_r[ptr_r] == ST_RUNNABLE) && (ptr_r != IDLE);
  assign sum = {1'b0, tick_r} + {1'b0, sleep_ticks};

  always_comb begin
    free_ok   = 1'b0;
    free_slot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_ok   = 1'b1;
        free_slot = slot_t'(i);
      end
    end
  end

  assign st.sweep_last = (ptr_r == LAST_IDX);
  assign st.pick_end   = hit || (next_r[ptr_r] == start_r) || (cnt_r == LAST_IDX);
  assign st.reap_end   = (next_r[ptr_r] == start_r) || (cnt_r == LAST_IDX);

  always_comb begin
    state_nxt   = state_r;
    used_nxt    = used_r;
    wake_nxt    = wake_r;
    next_nxt    = next_r;
    last_nxt    = last_r;
    run_nxt     = run_r;
    before_nxt  = before_r;
    tick_nxt    = tick_r;
    pre_nxt     = pre_r;
    status_nxt  = status_r;
    newslot_nxt = newslot_r;
    ptr_nxt     = ptr_r;
    start_nxt   = start_r;
    cnt_nxt     = cnt_r;
    pick_nxt    = pick_r;
    found_nxt   = found_r;
    pk_nxt      = pk_r;
    fk_nxt      = fk_r;
    havek_nxt   = havek_r;
    nx          = IDLE;
    case (cmd)
      DP_LOAD: begin
        before_nxt  = run_r;
        status_nxt  = 1'b0;
        newslot_nxt = '0;
        ptr_nxt     = '0;
        case (op)
          OP_TICK: tick_nxt = tick_r + 1'b1;
          OP_YIELD: begin
            if (state_r[run_r] == ST_RUNNING) state_nxt[run_r] = ST_RUNNABLE;
          end
          OP_SLEEP: begin
            if (sleep_ticks == '0) begin
              if (state_r[run_r] == ST_RUNNING) state_nxt[run_r] = ST_RUNNABLE;
            end else begin
              wake_nxt[run_r]  = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
              state_nxt[run_r] = ST_SLEEPING;
            end
          end
          OP_BLOCK: state_nxt[run_r] = ST_SLEEPING;
          OP_WAKE: begin
            if (used_r[target_slot] && state_r[target_slot] == ST_SLEEPING)
              state_nxt[target_slot] = ST_RUNNABLE;
          end
          OP_EXIT: state_nxt[run_r] = ST_DEAD;
          OP_CREATE: begin
            if (free_ok) begin
              used_nxt[free_slot]  = 1'b1;
              state_nxt[free_slot] = ST_RUNNABLE;
              wake_nxt[free_slot]  = '0;
              next_nxt[free_slot]  = next_r[last_r];
              next_nxt[last_r]     = free_slot;
              last_nxt             = free_slot;
              newslot_nxt          = free_slot;
            end else begin
              status_nxt = 1'b1;
            end
          end
          default: ;
        endcase
      end
      DP_SWEEP: begin
        if (used_r[ptr_r] && state_r[ptr_r] == ST_SLEEPING && wake_r[ptr_r] != '0 &&
            wake_r[ptr_r] <= tick_r) begin
          wake_nxt[ptr_r]  = '0;
          state_nxt[ptr_r] = ST_RUNNABLE;
        end
        ptr_nxt = ptr_r + 1'b1;
      end
      DP_PREEMPT: begin
        if (state_r[run_r] == ST_RUNNING) begin
          state_nxt[run_r] = ST_RUNNABLE;
          pre_nxt          = pre_r + 1'b1;
        end
      end
      DP_PICK_INIT: begin
        start_nxt = next_r[run_r];
        ptr_nxt   = next_r[run_r];
        cnt_nxt   = '0;
        found_nxt = 1'b0;
      end
      DP_PICK_STEP: begin
        if (hit) begin
          found_nxt = 1'b1;
          pick_nxt  = ptr_r;
        end
        ptr_nxt = next_r[ptr_r];
        cnt_nxt = cnt_r + 1'b1;
      end
      DP_SWITCH: begin
        if (found_r) nx = pick_r;
        else if (state_r[run_r] == ST_RUNNABLE && run_r != IDLE) nx = run_r;
        else nx = IDLE;
        if (nx == run_r) begin
          if (state_r[run_r] == ST_RUNNABLE) state_nxt[run_r] = ST_RUNNING;
        end else begin
          state_nxt[nx] = ST_RUNNING;
          run_nxt       = nx;
        end
      end
      DP_REAP_INIT: begin
        start_nxt = next_r[last_r];
        ptr_nxt   = next_r[last_r];
        cnt_nxt   = '0;
        havek_nxt = 1'b0;
      end
      DP_REAP_STEP: begin
        if (used_r[ptr_r]) begin
          if (ptr_r != run_r && ptr_r != IDLE && state_r[ptr_r] == ST_DEAD) begin
            used_nxt[ptr_r] = 1'b0;
          end else begin
            if (havek_r) next_nxt[pk_r] = ptr_r;
            else         fk_nxt = ptr_r;
            pk_nxt    = ptr_r;
            havek_nxt = 1'b1;
          end
        end
        ptr_nxt = next_r[ptr_r];
        cnt_nxt = cnt_r + 1'b1;
      end
      DP_REAP_CLOSE: begin
        if (havek_r) begin
          next_nxt[pk_r] = fk_r;
          last_nxt       = pk_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        state_r[i] <= ST_DEAD;
        wake_r[i]  <= '0;
        next_r[i]  <= '0;
      end
      state_r[0] <= ST_RUNNING;
      state_r[1] <= ST_RUNNABLE;
      next_r[0]  <= slot_t'(1);
      used_r     <= NUM_SLOTS'(2'b11);
      last_r     <= slot_t'(1);
      run_r      <= '0;
      tick_r     <= '0;
      pre_r      <= '0;
    end else begin
      state_r <= state_nxt;
      wake_r  <= wake_nxt;
      next_r  <= next_nxt;
      used_r  <= used_nxt;
      last_r  <= last_nxt;
      run_r   <= run_nxt;
      tick_r  <= tick_nxt;
      pre_r   <= pre_nxt;
    end
  end

  always_ff @(posedge clk) begin
    before_r  <= before_nxt;
    status_r  <= status_nxt;
    newslot_r <= newslot_nxt;
    ptr_r     <= ptr_nxt;
    start_r   <= start_nxt;
    cnt_r     <= cnt_nxt;
    pick_r    <= pick_nxt;
    found_r   <= found_nxt;
    pk_r      <= pk_nxt;
    fk_r      <= fk_nxt;
    havek_r   <= havek_nxt;
  end

  assign res.current_slot = run_r;
  assign res.switched     = (run_r != before_r);
  assign res.status       = status_r;
  assign res.new_slot     = newslot_r;
  assign res.tick_value   = tick_r;
  assign res.preemptions  = pre_r;

`ifndef SYNTHESIS
  a_run_used: assert property (@(posedge clk) disable iff (!rst_n) used_r[run_r])
    else $error("running slot is not in use");
  a_idle_used: assert property (@(posedge clk) disable iff (!rst_n) used_r[IDLE])
    else $error("idle slot was freed");
`endif

endmodule
`default_nettype wire

// File: verif/tb_round_robin_thread_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_thread_scheduler_core: self-checking bench of the scheduler
// Drives scheduling commands with random gaps on both streams, predicts each
// result with a behavioural model of the slot table and compares every field.
// ----------------------------------------------------------------------------
module tb_round_robin_thread_scheduler_core;
  import rrts_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // opcode[3:0], sleep_ticks[35:4], target_slot[39:36]
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // current_slot[3:0], switched[4], status[5], new_slot[9:6],
  // tick_value[41:10], preemptions[73:42], zero[79:74]
  logic [79:0] out_tdata;

  round_robin_thread_scheduler_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Shadow copy of the slot table.
  slot_state_t      sh_state [NUM_SLOTS];
  logic             sh_used  [NUM_SLOTS];
  logic [CNT_W-1:0] sh_wake  [NUM_SLOTS];
  slot_t            sh_next  [NUM_SLOTS];
  slot_t            sh_tail;
  slot_t            sh_run;
  logic [CNT_W-1:0] sh_ticks;
  logic [CNT_W-1:0] sh_preempt;

  result_t expected_results[$];
  int      fail_count;
  int      idle_cycles;
  bit      calm;            // no idling on either side while set

  // Round-robin pick from the successor of the running slot.
  function automatic slot_t pick_slot();
    slot_t first, n;
    first = sh_next[sh_run];
    n = first;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sh_used[n] && sh_state[n] == ST_RUNNABLE && n != slot_t'(IDLE_SLOT))
        return n;
      n = sh_next[n];
      if (n == first) break;
    end
    if (sh_state[sh_run] == ST_RUNNABLE && sh_run != slot_t'(IDLE_SLOT)) return sh_run;
    return slot_t'(IDLE_SLOT);
  endfunction

  function automatic void reschedule();
    slot_t nx;
    nx = pick_slot();
    if (nx == sh_run) begin
      if (sh_state[sh_run] == ST_RUNNABLE) sh_state[sh_run] = ST_RUNNING;
    end else begin
      sh_state[nx] = ST_RUNNING;
      sh_run = nx;
    end
  endfunction

  function automatic void yield_running();
    if (sh_state[sh_run] == ST_RUNNING) sh_state[sh_run] = ST_RUNNABLE;
    reschedule();
  endfunction

  function automatic void reap_dead();
    slot_t keep [NUM_SLOTS];
    int    k;
    slot_t first, n;
    k = 0;
    first = sh_next[sh_tail];
    n = first;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sh_used[n]) begin
        if (n != sh_run && n != slot_t'(IDLE_SLOT) && sh_state[n] == ST_DEAD)
          sh_used[n] = 1'b0;
        else begin
          keep[k] = n;
          k++;
        end
      end
      n = sh_next[n];
      if (n == first) break;
    end
    if (k == 0) return;
    for (int i = 0; i < k; i++) sh_next[keep[i]] = keep[(i + 1) % k];
    sh_tail = keep[k - 1];
  endfunction

  // Applies one command to the shadow table and queues the result it gives.
  function automatic void schedule_command(logic [3:0] op, logic [31:0] nticks,
                                           slot_t target);
    result_t    r;
    slot_t      prev;
    logic [32:0] sum;
    prev = sh_run;
    r = '0;
    case (op)
      OP_TICK: begin
        sh_ticks++;
        for (int s = 0; s < NUM_SLOTS; s++)
          if (sh_used[s] && sh_state[s] == ST_SLEEPING && sh_wake[s] != 0 &&
              sh_wake[s] <= sh_ticks) begin
            sh_wake[s]  = '0;
            sh_state[s] = ST_RUNNABLE;
          end
        if (sh_state[sh_run] == ST_RUNNING) begin
          sh_state[sh_run] = ST_RUNNABLE;
          sh_preempt++;
        end
        reschedule();
      end
      OP_YIELD: yield_running();
      OP_SLEEP: begin
        if (nticks == 0) yield_running();
        else begin
          sum = {1'b0, sh_ticks} + {1'b0, nticks};
          sh_wake[sh_run]  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          sh_state[sh_run] = ST_SLEEPING;
          reschedule();
        end
      end
      OP_BLOCK: sh_state[sh_run] = ST_SLEEPING;
      OP_WAKE:
        if (sh_used[target] && sh_state[target] == ST_SLEEPING)
          sh_state[target] = ST_RUNNABLE;
      OP_EXIT: begin
        sh_state[sh_run] = ST_DEAD;
        reschedule();
      end
      OP_CREATE: begin
        r.status = 1'b1;
        for (int s = 0; s < NUM_SLOTS; s++)
          if (!sh_used[s]) begin
            sh_used[s]  = 1'b1;
            sh_state[s] = ST_RUNNABLE;
            sh_wake[s]  = '0;
            sh_next[s]  = sh_next[sh_tail];
            sh_next[sh_tail] = slot_t'(s);
            sh_tail     = slot_t'(s);
            r.status    = 1'b0;
            r.new_slot  = slot_t'(s);
            break;
          end
      end
      OP_REAP:   reap_dead();
      OP_SWITCH: reschedule();
      default: ;
    endcase
    r.current_slot = sh_run;
    r.switched     = (sh_run != prev);
    r.tick_value   = sh_ticks;
    r.preemptions  = sh_preempt;
    expected_results.push_back(r);
  endfunction

  function automatic void reset_table();
    for (int s = 0; s < NUM_SLOTS; s++) begin
      sh_state[s] = ST_DEAD;
      sh_used[s]  = 1'b0;
      sh_wake[s]  = '0;
      sh_next[s]  = '0;
    end
    sh_state[0] = ST_RUNNING;
    sh_state[1] = ST_RUNNABLE;
    sh_used[0]  = 1'b1;
    sh_used[1]  = 1'b1;
    sh_next[0]  = slot_t'(1);
    sh_tail     = slot_t'(1);
    sh_run      = '0;
    sh_ticks    = '0;
    sh_preempt  = '0;
  endfunction

  function automatic bit gap_now();
    return !calm && ($urandom_range(99) < 32);
  endfunction

  // Sends one command; the prediction is made at the edge that accepts it.
  // tvalid is left high after acceptance, so the next command or a gap
  // takes over at the same edge; the caller drops it when traffic ends.
  task automatic send_command(logic [3:0] op, logic [31:0] nticks, slot_t target);
    while (gap_now()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {target, nticks, op};
    do @(posedge clk); while (!in_tready);
    schedule_command(op, nticks, target);
  endtask

  task automatic send_op(opcode_t op);
    send_command(op, $urandom, slot_t'($urandom));
  endtask

  // Result checker: stalls the receiver at random and compares each field.
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        idle_cycles <= 0;
        got = result_t'(out_tdata[73:0]);
        if (expected_results.size() == 0) begin
          $error("result with no command outstanding: %h", out_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.current_slot !== want.current_slot) begin
            $error("current_slot expected %0d got %0d", want.current_slot, got.current_slot);
            fail_count++;
          end
          if (got.switched !== want.switched) begin
            $error("switched expected %0d got %0d", want.switched, got.switched);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.new_slot !== want.new_slot) begin
            $error("new_slot expected %0d got %0d", want.new_slot, got.new_slot);
            fail_count++;
          end
          if (got.tick_value !== want.tick_value) begin
            $error("tick_value expected %0d got %0d", want.tick_value, got.tick_value);
            fail_count++;
          end
          if (got.preemptions !== want.preemptions) begin
            $error("preemptions expected %0d got %0d", want.preemptions,
                   got.preemptions);
            fail_count++;
          end
        end
      end else if (in_tvalid && in_tready) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      out_tready <= !gap_now();
    end
  end

  // Watchdog on a stream that has stopped moving.
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_round_robin_thread_scheduler_core failed");
      $finish;
    end
  end

  // Every opcode but yield plus an unknown one, create until the table is full,
  // wake of a slot that is not sleeping, sleep of zero ticks and the saturating wake tick.
  task automatic test_directed();
    send_op(OP_SWITCH);
    send_op(OP_TICK);
    send_command(OP_SLEEP, 32'd0, '0);
    for (int i = 0; i < 15; i++) send_op(OP_CREATE);
    send_command(OP_WAKE, 32'd0, 4'hF);
    send_command(OP_SLEEP, 32'hFFFF_FFFF, '0);
    send_op(OP_BLOCK);
    send_op(OP_EXIT);
    send_op(OP_REAP);
    send_command(4'hF, 32'hFFFF_FFFF, 4'hF);
  endtask

  // Mostly sensible process traffic with random operands and some noise.
  task automatic test_random(int count);
    int     k;
    logic [31:0] nt;
    for (int i = 0; i < count; i++) begin
      calm = (i >= 600 && i < 800);
      k = $urandom_range(99);
      case ($urandom_range(3))
        0: nt = $urandom;
        default: nt = $urandom_range(6);
      endcase
      if      (k < 30) send_op(OP_TICK);
      else if (k < 38) send_op(OP_YIELD);
      else if (k < 48) send_command(OP_SLEEP, nt, '0);
      else if (k < 53) send_op(OP_BLOCK);
      else if (k < 63) send_op(OP_WAKE);
      else if (k < 70) send_op(OP_EXIT);
      else if (k < 80) send_op(OP_CREATE);
      else if (k < 87) send_op(OP_REAP);
      else if (k < 96) send_op(OP_SWITCH);
      else send_command(4'($urandom_range(15, 9)), $urandom, slot_t'($urandom));
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    fail_count  = 0;
    idle_cycles = 0;
    calm        = 1'b0;
    reset_table();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1830);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0)
      $display("tb_round_robin_thread_scheduler_core passed");
    else
      $display("tb_round_robin_thread_scheduler_core failed");
    $finish;
  end

endmodule
